### design/lin_eso_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Back-EMF observer package
// Shared types, constants and saturation helpers for the extended state
// observer and its channel interfaces.
// ----------------------------------------------------------------------------
package lin_eso_pkg;

   // Saturation bound of wide intermediates, +-(2^47-1)
   localparam logic signed [47:0] WIDE_MAX   = 48'sh7FFF_FFFF_FFFF;
   localparam logic        [46:0] WIDE_MAG   = 47'h7FFF_FFFF_FFFF;
   localparam logic signed [50:0] SAT32_HI   = 51'sd2147483647;
   localparam logic signed [50:0] SAT32_LO   = -51'sd2147483648;
   // Normalisation applies above this magnitude (about 1e-4 in Q16.16)
   localparam logic        [63:0] NORM_MIN   = 64'd6;
   // Quarter-wave sine polynomial coefficients, Q16
   localparam logic        [16:0] SIN_C1     = 17'd4640;
   localparam logic        [16:0] SIN_C2     = 17'd42047;
   localparam logic        [16:0] SIN_C3     = 17'd102944;
   localparam logic        [16:0] SIN_ONE    = 17'd65536;
   localparam logic        [15:0] QUARTER    = 16'd16384;

   typedef enum logic [2:0] {
      CSR_ENABLE,
      CSR_BW_GAIN,
      CSR_BW_MIN,
      CSR_BW_MAX,
      CSR_RS,
      CSR_INV_L,
      CSR_L,
      CSR_TS
   } csr_index_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_WC,
      ST_B2,
      ST_B2T,
      ST_CORR,
      ST_CR,
      ST_F0,
      ST_BU,
      ST_B1E,
      ST_DT,
      ST_EMF,
      ST_Z2,
      ST_P1,
      ST_P2,
      ST_P3,
      ST_NUM1,
      ST_NUM2,
      ST_SQ1,
      ST_SQ2,
      ST_SQRT,
      ST_DIV,
      ST_DONE
   } state_type;

   typedef enum logic [1:0] {
      SHIFT_RAW,
      SHIFT_16,
      SHIFT_31
   } shift_type;

   typedef struct packed {
      logic signed [31:0] volt_alpha;
      logic signed [31:0] volt_beta;
      logic signed [31:0] cur_alpha;
      logic signed [31:0] cur_beta;
      logic signed [31:0] elec_speed;
      logic        [15:0] rotor_angle;
   } req_payload_type;

   typedef struct packed {
      logic signed [31:0] emf_alpha;
      logic signed [31:0] emf_beta;
      logic signed [31:0] est_cur_alpha;
      logic signed [31:0] est_cur_beta;
      logic signed [31:0] angle_error;
      logic        [30:0] bandwidth;
      logic               overflow_fault;
   } rsp_payload_type;

   // Saturate to signed 32 bits
   function automatic logic signed [31:0] sat32(input logic signed [50:0] v);
      logic signed [31:0] r;
      if (v > SAT32_HI) begin
         r = 32'sh7FFF_FFFF;
      end else if (v < SAT32_LO) begin
         r = 32'sh8000_0000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

   // True where sat32 would clip
   function automatic logic ovf32(input logic signed [50:0] v);
      return (v > SAT32_HI) || (v < SAT32_LO);
   endfunction

   // Saturate a sum to +-(2^47-1)
   function automatic logic signed [47:0] clamp_wide(input logic signed [50:0] v);
      logic signed [47:0] r;
      if (v > 51'(WIDE_MAX)) begin
         r = WIDE_MAX;
      end else if (v < -51'(WIDE_MAX)) begin
         r = -WIDE_MAX;
      end else begin
         r = v[47:0];
      end
      return r;
   endfunction

endpackage
`default_nettype wire

### design/lin_eso_req_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Observer input channel
// Valid/ready channel carrying one PWM sample of voltages, currents, speed
// and rotor angle.
// ----------------------------------------------------------------------------
interface lin_eso_req_if;
   import lin_eso_pkg::*;

   logic            valid;
   logic            ready;
   req_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface
`default_nettype wire

### design/lin_eso_rsp_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Observer result channel
// Valid/ready channel carrying back-EMF, current estimates, angle error,
// bandwidth and the fault flag.
// ----------------------------------------------------------------------------
interface lin_eso_rsp_if;
   import lin_eso_pkg::*;

   logic            valid;
   logic            ready;
   rsp_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface
`default_nettype wire

### design/linear_eso_back_emf_observer.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Linear extended state observer for back-EMF
// One sample transaction on req_chan gives one result transaction on
// rsp_chan. Registers are written through csr_wr_en/csr_index/csr_wdata
// only while idle; this binds the user, the block does not enforce it.
//
// All products go through one shared 24x33 multiplier under a sequencer.
// Square root is one bit pair a cycle and the normalising divide one
// quotient bit a cycle; the divide is cut short when the EMF magnitude is
// too small to normalise. req_chan.ready is high only while idle, so a
// new transaction is accepted only once the previous one has finished.
// The result sits in an output register; if rsp_chan is stalled when the
// next result is ready, the sequencer waits until the register drains.
// Synchronous reset clears the configuration registers, the observer
// state and the fault flag; no transaction is pending after reset.
// ----------------------------------------------------------------------------
module linear_eso_back_emf_observer (
   input  logic                        clock,
   input  logic                        reset,
   lin_eso_req_if.sink                 req_chan,
   lin_eso_rsp_if.source               rsp_chan,
   input  logic                        csr_wr_en,
   input  lin_eso_pkg::csr_index_type  csr_index,
   input  logic [30:0]                 csr_wdata
);
   import lin_eso_pkg::*;

   // Configuration
   logic        enable_ff;
   logic [30:0] bw_gain_ff, bw_min_ff, bw_max_ff, rs_ff, inv_l_ff, ind_ff, ts_ff;

   // Control
   state_type   state_ff, state_in;
   logic [1:0]  mph_ff, mph_in;
   logic [5:0]  cnt_ff;
   logic        axis_ff, trig_ff;
   logic        rsp_valid_ff;

   // Observer state
   logic signed [31:0] dist_ff [2];
   logic signed [31:0] est_ff  [2];
   logic               fault_ff;

   // Working registers
   req_payload_type    req_ff;
   rsp_payload_type    rsp_data_ff;
   logic [30:0]        wc_ff, wc_in;
   logic signed [47:0] b2t_ff, tmp_ff;
   logic signed [49:0] sum_ff, num_ff;
   logic [16:0]        z2_ff;
   logic signed [17:0] sn_ff, cs_ff;
   logic signed [31:0] emf_ff [2];
   logic signed [31:0] ang_ff;
   logic [63:0]        x_ff, res_ff, x_in, res_in;
   logic [31:0]        rem_ff, rem_in;
   logic [48:0]        dvd_ff, dvd_in;
   logic [80:0]        acc_ff, acc_in;

   logic req_acc, is_mul, mul_done;
   assign req_acc  = req_chan.valid && req_chan.ready;
   assign mul_done = (mph_ff == 2'd2);

   // Per-axis selections
   logic signed [31:0] cur_sel, volt_sel, dist_sel, est_sel;
   logic signed [32:0] err;
   assign cur_sel  = axis_ff ? req_ff.cur_beta  : req_ff.cur_alpha;
   assign volt_sel = axis_ff ? req_ff.volt_beta : req_ff.volt_alpha;
   assign dist_sel = dist_ff[axis_ff];
   assign est_sel  = est_ff[axis_ff];
   assign err      = 33'(est_sel) - 33'(cur_sel);

   // Quarter-wave argument for sine (trig_ff low) or cosine
   logic [15:0] ang_sel;
   logic [14:0] q15;
   logic [16:0] zq;
   assign ang_sel = trig_ff ? (req_ff.rotor_angle + QUARTER) : req_ff.rotor_angle;
   assign q15     = ang_sel[14] ? (15'(QUARTER) - {1'b0, ang_sel[13:0]})
                                : {1'b0, ang_sel[13:0]};
   assign zq      = {q15, 2'b00};

   // Operand selection for the shared multiplier
   logic signed [48:0] mul_a;
   logic signed [33:0] mul_b;
   shift_type          shift_sel;
   always_comb begin
      mul_a     = '0;
      mul_b     = '0;
      shift_sel = SHIFT_16;
      case (state_ff)
         ST_WC: begin
            mul_a = {18'b0, bw_gain_ff};
            mul_b = {{2{req_ff.elec_speed[31]}}, req_ff.elec_speed};
         end
         ST_B2: begin
            mul_a = {18'b0, wc_ff};
            mul_b = {3'b0, wc_ff};
         end
         ST_B2T: begin
            mul_a     = {tmp_ff[47], tmp_ff};
            mul_b     = {3'b0, ts_ff};
            shift_sel = SHIFT_31;
         end
         ST_CORR: begin
            mul_a = {b2t_ff[47], b2t_ff};
            mul_b = {err[32], err};
         end
         ST_CR: begin
            mul_a = {{17{cur_sel[31]}}, cur_sel};
            mul_b = {3'b0, rs_ff};
         end
         ST_F0: begin
            mul_a = {tmp_ff[47], tmp_ff};
            mul_b = {3'b0, inv_l_ff};
         end
         ST_BU: begin
            mul_a = {{17{volt_sel[31]}}, volt_sel};
            mul_b = {3'b0, inv_l_ff};
         end
         ST_B1E: begin
            mul_a = {17'b0, wc_ff, 1'b0};
            mul_b = {err[32], err};
         end
         ST_DT: begin
            mul_a     = {tmp_ff[47], tmp_ff};
            mul_b     = {3'b0, ts_ff};
            shift_sel = SHIFT_31;
         end
         ST_EMF: begin
            mul_a = {{17{dist_sel[31]}}, dist_sel};
            mul_b = {3'b0, ind_ff};
         end
         ST_Z2: begin
            mul_a = {32'b0, zq};
            mul_b = {17'b0, zq};
         end
         ST_P1: begin
            mul_a = {32'b0, z2_ff};
            mul_b = {17'b0, SIN_C1};
         end
         ST_P2: begin
            mul_a = {tmp_ff[47], tmp_ff};
            mul_b = {17'b0, z2_ff};
         end
         ST_P3: begin
            mul_a = {tmp_ff[47], tmp_ff};
            mul_b = {17'b0, zq};
         end
         ST_NUM1: begin
            mul_a     = {{17{emf_ff[0][31]}}, emf_ff[0]};
            mul_b     = {{16{cs_ff[17]}}, cs_ff};
            shift_sel = SHIFT_RAW;
         end
         ST_NUM2: begin
            mul_a     = {{17{emf_ff[1][31]}}, emf_ff[1]};
            mul_b     = {{16{sn_ff[17]}}, sn_ff};
            shift_sel = SHIFT_RAW;
         end
         ST_SQ1: begin
            mul_a     = {{17{emf_ff[0][31]}}, emf_ff[0]};
            mul_b     = {{2{emf_ff[0][31]}}, emf_ff[0]};
            shift_sel = SHIFT_RAW;
         end
         ST_SQ2: begin
            mul_a     = {{17{emf_ff[1][31]}}, emf_ff[1]};
            mul_b     = {{2{emf_ff[1][31]}}, emf_ff[1]};
            shift_sel = SHIFT_RAW;
         end
         default: begin
            mul_a = '0;
         end
      endcase
   end

   // Shared multiplier: magnitude times magnitude in two 24-bit halves
   logic [48:0] neg_a;
   logic [33:0] neg_b;
   logic [47:0] mag_a;
   logic [32:0] mag_b;
   logic [23:0] chunk;
   logic [56:0] pp;
   logic        mul_neg;
   assign neg_a   = -mul_a;
   assign neg_b   = -mul_b;
   assign mag_a   = mul_a[48] ? neg_a[47:0] : mul_a[47:0];
   assign mag_b   = mul_b[33] ? neg_b[32:0] : mul_b[32:0];
   assign chunk   = (mph_ff == 2'd0) ? mag_a[23:0] : mag_a[47:24];
   assign pp      = {33'b0, chunk} * {24'b0, mag_b};
   assign mul_neg = mul_a[48] ^ mul_b[33];

   always_comb begin
      case (mph_ff)
         2'd0:    acc_in = {24'b0, pp};
         2'd1:    acc_in = acc_ff + {pp, 24'b0};
         default: acc_in = acc_ff;
      endcase
   end

   // Product shift, saturation and sign
   logic [64:0]        mag_r;
   logic [46:0]        mag_sat;
   logic signed [47:0] mul_q;
   logic signed [49:0] mul_raw;
   always_comb begin
      case (shift_sel)
         SHIFT_31: mag_r = {15'b0, acc_ff[80:31]};
         default:  mag_r = acc_ff[80:16];
      endcase
      mag_sat = (mag_r > {18'b0, WIDE_MAG}) ? WIDE_MAG : mag_r[46:0];
      mul_q   = mul_neg ? -{1'b0, mag_sat} : {1'b0, mag_sat};
      mul_raw = mul_neg ? -{1'b0, acc_ff[48:0]} : {1'b0, acc_ff[48:0]};
   end

   // Writeback arithmetic
   logic signed [31:0] dist_new, est_new, emf_new;
   logic               dist_ovf, est_ovf;
   logic signed [47:0] deriv;
   logic signed [47:0] max_s, min_s, wc_cap;
   logic [16:0]        s_mag;
   logic signed [17:0] trig_val;
   assign dist_new = sat32(51'(dist_sel) - 51'(mul_q));
   assign dist_ovf = ovf32(51'(dist_sel) - 51'(mul_q));
   assign est_new  = sat32(51'(est_sel) + 51'(mul_q));
   assign est_ovf  = ovf32(51'(est_sel) + 51'(mul_q));
   assign emf_new  = sat32(-51'(mul_q));
   assign deriv    = clamp_wide(51'(sum_ff) + 51'(dist_sel) - 51'(mul_q));
   assign max_s    = {17'b0, bw_max_ff};
   assign min_s    = {17'b0, bw_min_ff};
   assign wc_cap   = (mul_q > max_s) ? max_s : mul_q;
   assign wc_in    = (wc_cap < min_s) ? bw_min_ff : wc_cap[30:0];
   assign s_mag    = (mul_q > 48'(SIN_ONE)) ? SIN_ONE : mul_q[16:0];
   assign trig_val = ang_sel[15] ? -{1'b0, s_mag} : {1'b0, s_mag};

   // Square root step, one bit pair per cycle
   logic [63:0] bit_v, trial;
   assign bit_v = 64'd1 << (6'd62 - {cnt_ff[4:0], 1'b0});
   assign trial = res_ff + bit_v;
   always_comb begin
      if (x_ff >= trial) begin
         x_in   = x_ff - trial;
         res_in = (res_ff >> 1) + bit_v;
      end else begin
         x_in   = x_ff;
         res_in = res_ff >> 1;
      end
   end

   // Restoring divide step, one quotient bit per cycle
   logic [49:0] num_neg;
   logic [48:0] num_mag;
   logic [32:0] rem_sh, rem_sub;
   logic        rem_ge, norm_ok;
   assign num_neg = -num_ff;
   assign num_mag = num_ff[49] ? num_neg[48:0] : num_ff[48:0];
   assign rem_sh  = {rem_ff, dvd_ff[48]};
   assign rem_sub = rem_sh - {1'b0, res_ff[31:0]};
   assign rem_ge  = (rem_sh >= {1'b0, res_ff[31:0]});
   assign rem_in  = rem_ge ? rem_sub[31:0] : rem_sh[31:0];
   assign dvd_in  = {dvd_ff[47:0], rem_ge};
   assign norm_ok = (res_ff > NORM_MIN);

   logic signed [50:0] quo_s, short_s;
   assign quo_s   = num_ff[49] ? -{2'b0, dvd_in} : {2'b0, dvd_in};
   assign short_s = num_ff[49] ? -{18'b0, num_mag[48:16]} : {18'b0, num_mag[48:16]};

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               state_in = enable_ff ? ST_WC : ST_DONE;
            end
         end
         ST_WC:   if (mul_done) state_in = ST_B2;
         ST_B2:   if (mul_done) state_in = ST_B2T;
         ST_B2T:  if (mul_done) state_in = ST_CORR;
         ST_CORR: if (mul_done) state_in = ST_CR;
         ST_CR:   if (mul_done) state_in = ST_F0;
         ST_F0:   if (mul_done) state_in = ST_BU;
         ST_BU:   if (mul_done) state_in = ST_B1E;
         ST_B1E:  if (mul_done) state_in = ST_DT;
         ST_DT:   if (mul_done) state_in = ST_EMF;
         ST_EMF:  if (mul_done) state_in = axis_ff ? ST_Z2 : ST_CORR;
         ST_Z2:   if (mul_done) state_in = ST_P1;
         ST_P1:   if (mul_done) state_in = ST_P2;
         ST_P2:   if (mul_done) state_in = ST_P3;
         ST_P3:   if (mul_done) state_in = trig_ff ? ST_NUM1 : ST_Z2;
         ST_NUM1: if (mul_done) state_in = ST_NUM2;
         ST_NUM2: if (mul_done) state_in = ST_SQ1;
         ST_SQ1:  if (mul_done) state_in = ST_SQ2;
         ST_SQ2:  if (mul_done) state_in = ST_SQRT;
         ST_SQRT: if (cnt_ff == 6'd31) state_in = ST_DIV;
         ST_DIV: begin
            if (!norm_ok || cnt_ff == 6'd48) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Multiplier phase
   always_comb begin
      is_mul = state_ff inside {[ST_WC:ST_SQ2]};
      if (is_mul && !mul_done) begin
         mph_in = mph_ff + 2'd1;
      end else begin
         mph_in = 2'd0;
      end
   end

   // Channel outputs
   always_comb begin
      req_chan.ready   = (state_ff == ST_IDLE);
      rsp_chan.valid   = rsp_valid_ff;
      rsp_chan.payload = rsp_data_ff;
   end

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff  <= 1'b0;
         bw_gain_ff <= '0;
         bw_min_ff  <= '0;
         bw_max_ff  <= '0;
         rs_ff      <= '0;
         inv_l_ff   <= '0;
         ind_ff     <= '0;
         ts_ff      <= '0;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_ENABLE:  enable_ff  <= csr_wdata[0];
            CSR_BW_GAIN: bw_gain_ff <= csr_wdata;
            CSR_BW_MIN:  bw_min_ff  <= csr_wdata;
            CSR_BW_MAX:  bw_max_ff  <= csr_wdata;
            CSR_RS:      rs_ff      <= csr_wdata;
            CSR_INV_L:   inv_l_ff   <= csr_wdata;
            CSR_L:       ind_ff     <= csr_wdata;
            CSR_TS:      ts_ff      <= csr_wdata;
            default:     enable_ff  <= enable_ff;
         endcase
      end
   end

   // Sequencer control and observer state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         mph_ff       <= 2'd0;
         cnt_ff       <= 6'd0;
         axis_ff      <= 1'b0;
         trig_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         fault_ff     <= 1'b0;
         dist_ff[0]   <= '0;
         dist_ff[1]   <= '0;
         est_ff[0]    <= '0;
         est_ff[1]    <= '0;
      end else begin
         state_ff <= state_in;
         mph_ff   <= mph_in;

         if (state_ff == ST_DONE && state_in == ST_IDLE) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end

         case (state_ff)
            ST_IDLE: begin
               axis_ff <= 1'b0;
               trig_ff <= 1'b0;
               cnt_ff  <= 6'd0;
               if (req_acc && !enable_ff) begin
                  fault_ff   <= 1'b0;
                  dist_ff[0] <= '0;
                  dist_ff[1] <= '0;
                  est_ff[0]  <= '0;
                  est_ff[1]  <= '0;
               end
            end
            ST_CORR: begin
               if (mul_done) begin
                  dist_ff[axis_ff] <= dist_new;
                  fault_ff         <= fault_ff | dist_ovf;
               end
            end
            ST_DT: begin
               if (mul_done) begin
                  est_ff[axis_ff] <= est_new;
                  fault_ff        <= fault_ff | est_ovf;
               end
            end
            ST_EMF:  if (mul_done) axis_ff <= 1'b1;
            ST_P3:   if (mul_done) trig_ff <= 1'b1;
            ST_SQRT: cnt_ff <= (cnt_ff == 6'd31) ? 6'd0 : cnt_ff + 6'd1;
            ST_DIV:  cnt_ff <= cnt_ff + 6'd1;
            default: cnt_ff <= 6'd0;
         endcase
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               req_ff <= req_chan.payload;
               if (!enable_ff) begin
                  wc_ff     <= bw_min_ff;
                  emf_ff[0] <= '0;
                  emf_ff[1] <= '0;
                  ang_ff    <= '0;
               end
            end
         end
         ST_WC:   if (mul_done) wc_ff  <= wc_in;
         ST_B2:   if (mul_done) tmp_ff <= mul_q;
         ST_B2T:  if (mul_done) b2t_ff <= mul_q;
         ST_CR:   if (mul_done) tmp_ff <= mul_q;
         ST_F0:   if (mul_done) sum_ff <= -50'(mul_q);
         ST_BU:   if (mul_done) sum_ff <= sum_ff + 50'(mul_q);
         ST_B1E:  if (mul_done) tmp_ff <= deriv;
         ST_EMF:  if (mul_done) emf_ff[axis_ff] <= emf_new;
         ST_Z2:   if (mul_done) z2_ff <= mul_q[16:0];
         ST_P1:   if (mul_done) tmp_ff <= {31'b0, SIN_C2} - mul_q;
         ST_P2:   if (mul_done) tmp_ff <= {31'b0, SIN_C3} - mul_q;
         ST_P3: begin
            if (mul_done) begin
               if (trig_ff) cs_ff <= trig_val;
               else         sn_ff <= trig_val;
            end
         end
         ST_NUM1: if (mul_done) num_ff <= -mul_raw;
         ST_NUM2: if (mul_done) num_ff <= num_ff - mul_raw;
         ST_SQ1:  if (mul_done) x_ff <= acc_ff[63:0];
         ST_SQ2: begin
            if (mul_done) begin
               x_ff   <= x_ff + acc_ff[63:0];
               res_ff <= '0;
            end
         end
         ST_SQRT: begin
            x_ff   <= x_in;
            res_ff <= res_in;
            if (cnt_ff == 6'd31) begin
               dvd_ff <= num_mag;
               rem_ff <= '0;
            end
         end
         ST_DIV: begin
            if (!norm_ok) begin
               ang_ff <= sat32(short_s);
            end else begin
               rem_ff <= rem_in;
               dvd_ff <= dvd_in;
               if (cnt_ff == 6'd48) begin
                  ang_ff <= sat32(quo_s);
               end
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_data_ff.emf_alpha      <= emf_ff[0];
               rsp_data_ff.emf_beta       <= emf_ff[1];
               rsp_data_ff.est_cur_alpha  <= est_ff[0];
               rsp_data_ff.est_cur_beta   <= est_ff[1];
               rsp_data_ff.angle_error    <= ang_ff;
               rsp_data_ff.bandwidth      <= wc_ff;
               rsp_data_ff.overflow_fault <= fault_ff;
            end
         end
         default: begin
            z2_ff <= z2_ff;
         end
      endcase
   end

`ifndef ASSERT_OFF
   // An accepted transaction always starts the sequencer
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_acc |=> (state_ff != ST_IDLE))
      else $error("sequencer idle after accepting a transaction");

   // Disabled observer gives zero EMF, angle error and fault
   a_disabled_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && !enable_ff) |->
         (rsp_chan.payload.overflow_fault == 1'b0 &&
          rsp_chan.payload.angle_error == '0 &&
          rsp_chan.payload.emf_alpha == '0 &&
          rsp_chan.payload.emf_beta == '0))
      else $error("non-zero result while observer disabled");

   // Fault stays set while the observer remains enabled
   a_fault_sticky: assert property (@(posedge clock) disable iff (reset)
      ($past(!reset) && enable_ff && $past(enable_ff) && $past(fault_ff)) |-> fault_ff)
      else $error("fault flag cleared while enabled");
`endif

endmodule
`default_nettype wire
